// File: hdl/olisd_pkg.sv
`default_nettype none

package olisd_pkg;

    // Action codes carried by an input item.
    localparam logic [1:0] ACT_FRONT  = 2'd0;
    localparam logic [1:0] ACT_BACK   = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;
    localparam logic [1:0] ACT_DELETE = 2'd3;

    // Width of the reported entry count.
    localparam int unsigned COUNT_W = 5;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Operation broadcast to every cell.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_FRONT,
        OP_BACK,
        OP_DELETE
    } t_op;

    // Control bundle shared by all cells of the row.
    typedef struct packed {
        t_op         op;
        logic        cmp;
        logic [31:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hdl/ordered_list_insert_search_delete_top.sv
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values, head first, held in a row
// of cells. Each cell keeps one entry and exchanges it with its neighbors.
// Input channel: i_action and i_value are taken on a transfer, which happens at
// a rising edge with i_start high and o_busy low. Actions are insert at front,
// insert at back, search, and delete of the first match from the head.
// Output channel: one result per item, shown for exactly one cycle with o_valid
// high: o_hit, o_dropped_full and o_entry_count (count modulo 32).
// The receiver cannot stall; each result must be taken in its cycle.
// Timing: the transfer edge samples the per-cell compares; the next edge applies
// the shift in every cell and registers the result, which is visible in the
// following cycle. o_busy is high for one cycle after each transfer, so a new
// item is not taken while the last one executes. The delete path carries a
// one-bit match flag through the row, so its length grows with DEPTH.
// Reset (synchronous, active low) empties the list at once; no clearing pass.
module ordered_list_insert_search_delete_top
    import olisd_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [1:0]           i_action,
    input  wire signed [31:0]   i_value,
    output logic                o_busy,
    output logic                o_valid,
    output logic                o_hit,
    output logic                o_dropped_full,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state         r_state;
    t_state         n_state;
    logic [1:0]     r_action;
    logic [31:0]    r_value;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_out_valid;
    logic           r_out_hit;
    logic           r_out_dropped;
    logic [CW-1:0]  r_out_count;
    logic           n_accept;
    logic           n_full;
    logic           n_hit;
    logic           n_is_insert;
    t_cell_ctl      n_ctl;

    logic [31:0]    w_data  [DEPTH];
    logic           w_valid [DEPTH];
    logic           w_seen  [DEPTH];

    assign n_accept    = i_start && !o_busy;
    assign n_full      = (r_count == CW'(DEPTH));
    assign n_is_insert = (r_action == ACT_FRONT) || (r_action == ACT_BACK);
    assign n_hit       = w_seen[DEPTH-1] && !n_is_insert;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs and the control broadcast to the row.
    always_comb begin
        o_busy      = (r_state == ST_EXEC);
        n_ctl.op    = OP_HOLD;
        n_ctl.cmp   = n_accept;
        n_ctl.value = o_busy ? r_value : i_value;
        if (r_state == ST_EXEC) begin
            unique case (r_action)
                ACT_FRONT:  n_ctl.op = n_full ? OP_HOLD : OP_FRONT;
                ACT_BACK:   n_ctl.op = n_full ? OP_HOLD : OP_BACK;
                ACT_SEARCH: n_ctl.op = OP_HOLD;
                ACT_DELETE: n_ctl.op = OP_DELETE;
                default:    n_ctl.op = OP_HOLD;
            endcase
        end
    end

    // Entry count after the executed item.
    always_comb begin
        n_count = r_count;
        if (r_state == ST_EXEC) begin
            if (n_is_insert && !n_full) begin
                n_count = r_count + CW'(1);
            end else if ((r_action == ACT_DELETE) && n_hit) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= (r_state == ST_EXEC);
        end
    end

    // Command and result payload.
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (r_state == ST_EXEC) begin
            r_out_hit     <= n_hit;
            r_out_dropped <= n_is_insert && n_full;
            r_out_count   <= n_count;
        end
    end

    // Row of cells; cell 0 is the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] w_left_data;
        logic        w_left_valid;
        logic [31:0] w_right_data;
        logic        w_right_valid;
        logic        w_seen_in;

        if (g == 0) begin : g_head
            assign w_left_data  = r_value;
            assign w_left_valid = 1'b1;
            assign w_seen_in    = 1'b0;
        end else begin : g_body
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_seen_in    = w_seen[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        olisd_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (n_ctl),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .i_seen        (w_seen_in),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_seen        (w_seen[g])
        );
    end

    // Report the count in the fixed output width.
    logic [CW+COUNT_W-1:0] w_count_ext;
    assign w_count_ext    = {{COUNT_W{1'b0}}, r_out_count};
    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_dropped_full = r_out_dropped;
    assign o_entry_count  = w_count_ext[COUNT_W-1:0];

    // A result strobe follows each transfer, after the execute state.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> ##1 o_valid)
        else $error("result strobe missing after transfer");

    // The block is ready again whenever a result is shown.
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("busy while a result is shown");

    // A dropped insert only happens on a full list.
    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped_full) |-> (r_out_count == CW'(DEPTH)))
        else $error("drop reported on a list that is not full");

    // Hit and drop never come together.
    a_hit_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_dropped_full))
        else $error("hit and drop both set");

    // The count never exceeds the storage.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

endmodule

`default_nettype wire

// File: hdl/olisd_cell.sv
`default_nettype none

module olisd_cell
    import olisd_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  wire [31:0]      i_left_data,
    input  wire             i_left_valid,
    input  wire [31:0]      i_right_data,
    input  wire             i_right_valid,
    input  wire             i_seen,
    output logic [31:0]     o_data,
    output logic            o_valid,
    output logic            o_seen
);

    logic [31:0] r_data;
    logic        r_valid;
    logic        r_eq;
    logic        n_take_right;

    // A match here or anywhere nearer the head moves the deletion front past this cell.
    assign o_seen       = i_seen | r_eq;
    assign n_take_right = (i_ctl.op == OP_DELETE) && o_seen;

    // Equality is sampled in the transfer cycle of a new item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_eq <= r_valid && (r_data == i_ctl.value);
        end
    end

    // Valid flag follows the same moves as the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_FRONT: r_valid <= i_left_valid;
                OP_BACK: begin
                    if (!r_valid && i_left_valid) begin
                        r_valid <= 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (n_take_right) begin
                        r_valid <= i_right_valid;
                    end
                end
                OP_HOLD: r_valid <= r_valid;
                default: r_valid <= r_valid;
            endcase
        end
    end

    // Stored value: shift right on front insert, fill the first free cell on back
    // insert, shift left from the match onward on delete.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_FRONT: r_data <= i_left_data;
            OP_BACK: begin
                if (!r_valid && i_left_valid) begin
                    r_data <= i_ctl.value;
                end
            end
            OP_DELETE: begin
                if (n_take_right) begin
                    r_data <= i_right_data;
                end
            end
            OP_HOLD: r_data <= r_data;
            default: r_data <= r_data;
        endcase
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

`default_nettype wire
